// File: hdl/assert_macros.svh
// assertion macros shared by the rtl of the window rms block
// expects a clock named clk and a synchronous active high reset named rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define CHK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tcwr_pkg.sv
// widths, register indexes and types of the two channel window rms block
// no dependencies
`default_nettype none

package tcwr_pkg;

  localparam int OFFSET_W   = 12;  // raw zero offset registers
  localparam int SCALE_W    = 32;  // q16.16 scale registers
  localparam int WIN_W      = 11;  // window length register and sample count
  localparam int SUM_W      = 35;  // square sum accumulators
  localparam int MEAN_SHIFT = 16;  // mean is shifted up before the root
  localparam int ROOT_W     = 26;  // floor sqrt of a 51 bit radicand
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;  // shared subtractor width
  localparam int MUL_B_W    = SCALE_W / 2; // multiplier takes half a scale
  localparam int PROD_W     = ROOT_W + MUL_B_W;
  localparam int ACC_W      = ROOT_W + SCALE_W;
  localparam int OUT_SHIFT  = 24;
  localparam int RMS_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 6;   // holds the longest iteration count

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_VOLT_OFFSET   = 3'd0;
  localparam cfg_index_t REG_AMP_OFFSET    = 3'd1;
  localparam cfg_index_t REG_VOLT_SCALE    = 3'd2;
  localparam cfg_index_t REG_AMP_SCALE     = 3'd3;
  localparam cfg_index_t REG_WINDOW_LENGTH = 3'd4;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [RMS_W-1:0]  rms_t;
  typedef logic [SCALE_W-1:0] scale_t;

endpackage

`default_nettype wire

// File: hdl/two_channel_window_rms.sv
// two channel windowed true rms: accumulate, divide, root and scale
// depends on tcwr_pkg and assert_macros.svh
//
//   channel  direction  handshake            payload
//   in       to block   in_valid, in_stall   volt_sample, amp_sample
//   out      from block out_valid, out_stall volt_rms, amp_rms
//   cfg      to block   cfg_write            cfg_index, cfg_data
//
// an item that does not close the window passes accept, square volt, square amp and add,
//   and count; one 26x16 multiplier and one adder are shared
// an item that closes the window adds, per channel, 35 divide steps, 26 root steps on
//   the one shared subtractor, then scaling: low multiply, high multiply, sum and clip
// the result sits in an output register, so input is taken while it waits;
//   only a second closing window stalls until the first result is taken
// reset restores the register defaults and clears both sums and the count
`default_nettype none

module two_channel_window_rms #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  wire  logic                            clk,
  input  wire  logic                            rst,
  // configuration
  input  wire  logic                            cfg_write,
  input  wire  tcwr_pkg::cfg_index_t            cfg_index,
  input  wire  logic [tcwr_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample items
  input  wire  logic                            in_valid,
  output logic                                  in_stall,
  input  wire  logic [SAMPLE_BITS-1:0]          volt_sample,
  input  wire  logic [SAMPLE_BITS-1:0]          amp_sample,
  // result items
  output logic                                  out_valid,
  input  wire  logic                            out_stall,
  output tcwr_pkg::rms_t                        volt_rms,
  output tcwr_pkg::rms_t                        amp_rms
);

  import tcwr_pkg::*;

  // difference of a sample and an offset, wide enough for either
  localparam int DIFF_W = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;
  // largest window the count can reach
  localparam int WIN_CAP = (MAX_WINDOW < (2 ** WIN_W) - 1) ? MAX_WINDOW : (2 ** WIN_W) - 1;
  localparam logic [WIN_W-1:0] WIN_CAP_V = WIN_CAP[WIN_W-1:0];

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ_V    = 4'd1;  // square volt difference
  localparam logic [3:0] S_SQ_A    = 4'd2;  // add volt square, square amp
  localparam logic [3:0] S_SQ_END  = 4'd3;  // add amp square, count sample
  localparam logic [3:0] S_DIV     = 4'd4;  // one quotient bit per cycle
  localparam logic [3:0] S_SQRT    = 4'd5;  // one root bit per cycle
  localparam logic [3:0] S_MUL_LO  = 4'd6;
  localparam logic [3:0] S_MUL_HI  = 4'd7;
  localparam logic [3:0] S_MUL_SUM = 4'd8;
  localparam logic [3:0] S_SAT     = 4'd9;

  // configuration registers
  logic [OFFSET_W-1:0] volt_offset;
  logic [OFFSET_W-1:0] amp_offset;
  scale_t              volt_scale;
  scale_t              amp_scale;
  logic [WIN_W-1:0]    window_length;

  // window state
  sum_t             vsum;
  sum_t             asum;
  logic [WIN_W-1:0] taken;

  // sequencer and datapath registers
  logic [3:0]        state;
  logic              chan;      // 0 volt, 1 amp
  logic [STEP_W-1:0] step;
  logic [DIFF_W-1:0] dv;
  logic [DIFF_W-1:0] da;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic [RAD_W-1:0]  work;      // dividend/quotient, then radicand
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  rms_t              volt_res;

  // combinational helpers
  logic [WIN_W-1:0]   n_eff;
  logic [DIFF_W-1:0]  vs_ext;
  logic [DIFF_W-1:0]  as_ext;
  logic [DIFF_W-1:0]  vo_ext;
  logic [DIFF_W-1:0]  ao_ext;
  logic [DIFF_W-1:0]  dv_next;
  logic [DIFF_W-1:0]  da_next;
  logic [ROOT_W-1:0]  mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  sum_t               add_a;
  logic [SUM_W:0]     add_s;
  sum_t               sat_sum;
  logic [REM_W-1:0]   sub_a;
  logic [REM_W-1:0]   sub_b;
  logic [REM_W:0]     sub_d;
  logic               fits;
  logic [WIN_W:0]     div_t;
  logic [REM_W-1:0]   sqrt_t;
  scale_t             scale_sel;
  rms_t               rms_sat;
  logic [WIN_W-1:0]   taken_inc;
  logic               out_free;

  // zero means one sample, anything above the cap is the cap
  always_comb begin
    if (window_length == '0) begin
      n_eff = WIN_W'(1);
    end else if (window_length > WIN_CAP_V) begin
      n_eff = WIN_CAP_V;
    end else begin
      n_eff = window_length;
    end
  end

  // absolute differences from the raw zero codes
  assign vs_ext  = DIFF_W'(volt_sample);
  assign as_ext  = DIFF_W'(amp_sample);
  assign vo_ext  = DIFF_W'(volt_offset);
  assign ao_ext  = DIFF_W'(amp_offset);
  assign dv_next = (vs_ext >= vo_ext) ? (vs_ext - vo_ext) : (vo_ext - vs_ext);
  assign da_next = (as_ext >= ao_ext) ? (as_ext - ao_ext) : (ao_ext - as_ext);

  assign scale_sel = chan ? amp_scale : volt_scale;

  // shared multiplier: squares while accumulating, root times scale halves later
  always_comb begin
    unique case (state)
      S_SQ_V: begin
        mul_a = ROOT_W'(dv);
        mul_b = MUL_B_W'(dv);
      end
      S_SQ_A: begin
        mul_a = ROOT_W'(da);
        mul_b = MUL_B_W'(da);
      end
      S_MUL_HI: begin
        mul_a = root;
        mul_b = scale_sel[SCALE_W-1:MUL_B_W];
      end
      default: begin
        mul_a = root;
        mul_b = scale_sel[MUL_B_W-1:0];
      end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // shared saturating accumulate
  assign add_a   = (state == S_SQ_A) ? vsum : asum;
  assign add_s   = (SUM_W + 1)'(add_a) + (SUM_W + 1)'(prod);
  assign sat_sum = add_s[SUM_W] ? {SUM_W{1'b1}} : add_s[SUM_W-1:0];

  // shared trial subtractor: restoring divide step or root digit step
  assign div_t  = {rem[WIN_W-1:0], work[SUM_W-1]};
  assign sqrt_t = {rem[REM_W-3:0], work[RAD_W-1 -: 2]};
  always_comb begin
    if (state == S_SQRT) begin
      sub_a = sqrt_t;
      sub_b = {root, 2'b01};
    end else begin
      sub_a = REM_W'(div_t);
      sub_b = REM_W'(n_eff);
    end
  end
  assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
  assign fits  = !sub_d[REM_W];

  // drop the fraction bits and clip to the output width
  assign rms_sat = (|acc[ACC_W-1:OUT_SHIFT+RMS_W]) ? {RMS_W{1'b1}}
                                                  : acc[OUT_SHIFT +: RMS_W];

  assign taken_inc = taken + WIN_W'(1);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_offset   <= OFFSET_W'(2048);
      amp_offset    <= OFFSET_W'(2048);
      volt_scale    <= SCALE_W'(65536);
      amp_scale     <= SCALE_W'(65536);
      window_length <= WIN_W'(400);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VOLT_OFFSET:   volt_offset   <= cfg_data[OFFSET_W-1:0];
        REG_AMP_OFFSET:    amp_offset    <= cfg_data[OFFSET_W-1:0];
        REG_VOLT_SCALE:    volt_scale    <= cfg_data[SCALE_W-1:0];
        REG_AMP_SCALE:     amp_scale     <= cfg_data[SCALE_W-1:0];
        REG_WINDOW_LENGTH: window_length <= cfg_data[WIN_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chan      <= 1'b0;
      step      <= '0;
      vsum      <= '0;
      asum      <= '0;
      taken     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dv    <= dv_next;
            da    <= da_next;
            state <= S_SQ_V;
          end
        end
        S_SQ_V: begin
          prod  <= mul_p;
          state <= S_SQ_A;
        end
        S_SQ_A: begin
          vsum  <= sat_sum;
          prod  <= mul_p;
          state <= S_SQ_END;
        end
        S_SQ_END: begin
          asum <= sat_sum;
          if (taken_inc < n_eff) begin
            taken <= taken_inc;
            state <= S_IDLE;
          end else begin
            // window closed: start on the volt channel
            taken <= '0;
            chan  <= 1'b0;
            step  <= '0;
            rem   <= '0;
            work  <= RAD_W'(vsum);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= fits ? sub_d[REM_W-1:0] : REM_W'(div_t);
          step <= step + STEP_W'(1);
          if (step == DIV_LAST) begin
            // quotient is complete: load it as radicand, shifted up
            work  <= RAD_W'({work[SUM_W-2:0], fits, {MEAN_SHIFT{1'b0}}});
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_SQRT;
          end else begin
            work[SUM_W-1:0] <= {work[SUM_W-2:0], fits};
          end
        end
        S_SQRT: begin
          rem  <= fits ? sub_d[REM_W-1:0] : sqrt_t;
          root <= {root[ROOT_W-2:0], fits};
          work <= {work[RAD_W-3:0], 2'b00};
          step <= step + STEP_W'(1);
          if (step == ROOT_LAST) begin
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod  <= mul_p;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= ACC_W'(prod);
          prod  <= mul_p;
          state <= S_MUL_SUM;
        end
        S_MUL_SUM: begin
          acc   <= acc + {prod, {MUL_B_W{1'b0}}};
          state <= S_SAT;
        end
        S_SAT: begin
          if (!chan) begin
            // volt done: run the same sequence on the amp sum
            volt_res <= rms_sat;
            chan     <= 1'b1;
            step     <= '0;
            rem      <= '0;
            work     <= RAD_W'(asum);
            state    <= S_DIV;
          end else if (out_free) begin
            volt_rms  <= volt_res;
            amp_rms   <= rms_sat;
            out_valid <= 1'b1;
            vsum      <= '0;
            asum      <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "assert_macros.svh"

  // divide remainder always stays below the divisor
  `CHK_IMPLIES(a_div_rem, state == S_DIV, rem[WIN_W-1:0] < n_eff, "divide remainder not below window")
  // root remainder never exceeds twice the partial root
  `CHK_IMPLIES(a_sqrt_rem, state == S_SQRT, rem <= REM_W'({root, 1'b0}), "root remainder out of range")
  // delivering a result empties the window
  `CHK_NEXT(a_win_clear, state == S_SAT && chan && out_free, out_valid && vsum == '0 && asum == '0 && taken == '0, "window not cleared on result")

endmodule

`default_nettype wire
